>>> src/sspc_pkg.sv
// shared types and constants for the sensor scratchpad checker
// no dependencies; imported by every module of the block
package sspc_pkg;

   typedef logic [7:0] byte_type;
   typedef logic signed [15:0] centi_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_STUCK   = 2'd1,
      STATUS_CRC_ERR = 2'd2
   } status_type;

   // reflected x^8+x^5+x^4+1
   localparam byte_type CRC_POLY  = 8'h8C;
   localparam byte_type CRC_INIT  = 8'h00;
   localparam byte_type AND_INIT  = 8'hFF;
   localparam byte_type OR_INIT   = 8'h00;

   localparam centi_type CENTI_MAX = 16'sh7FFF;
   localparam centi_type CENTI_MIN = -16'sh8000;

endpackage

>>> src/sspc_crc8.sv
// byte-wide 1-wire crc-8 update, lsb first
// depends on sspc_pkg
module sspc_crc8 (
   input  sspc_pkg::byte_type crc_cur,
   input  sspc_pkg::byte_type data,
   output sspc_pkg::byte_type crc_next
);
   import sspc_pkg::*;

   always_comb begin
      byte_type c;
      byte_type d;
      c = crc_cur;
      d = data;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ d[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      crc_next = c;
   end

endmodule

>>> src/sspc_convert.sv
// converts a signed reading in 1/16 degree to saturated hundredths of a degree
// depends on sspc_pkg
module sspc_convert (
   input  sspc_pkg::byte_type  reading_low,
   input  sspc_pkg::byte_type  reading_high,
   output sspc_pkg::centi_type centi
);
   import sspc_pkg::*;

   logic signed [20:0] raw_ext;
   logic signed [20:0] prod;
   logic signed [20:0] prod_adj;
   logic signed [18:0] quot;

   assign raw_ext  = 21'(signed'({reading_high, reading_low}));
   // times 25 as 16 + 8 + 1
   assign prod     = (raw_ext <<< 4) + (raw_ext <<< 3) + raw_ext;
   // bias negatives so the shift truncates toward zero
   assign prod_adj = prod + (prod[20] ? 21'sd3 : 21'sd0);
   assign quot     = 19'(prod_adj >>> 2);

   always_comb begin
      if (quot > 19'(CENTI_MAX)) begin
         centi = CENTI_MAX;
      end else if (quot < 19'(CENTI_MIN)) begin
         centi = CENTI_MIN;
      end else begin
         centi = 16'(quot);
      end
   end

endmodule

>>> src/sensor_scratchpad_checker.sv
// sensor scratchpad checker: crc-8, stuck-line check and temperature conversion
// a frame's last byte passes the input register, and its result is then registered in the result register
// throughput: one byte per cycle; a frame's last byte waits only while the previous
// result is still held by a stalled sink
// reset: synchronous, clears both valid flags and all frame accumulators
// depends on sspc_pkg, sspc_crc8, sspc_convert
module sensor_scratchpad_checker #(
   parameter int FRAME_BYTES = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sspc_pkg::byte_type   req_data_byte,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sspc_pkg::status_type rsp_status,
   output sspc_pkg::centi_type  rsp_centi_deg
);
   import sspc_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES);

   // input register
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       in_start_ff;

   // frame state
   logic [CW-1:0] count_ff, count_in;
   byte_type      crc_ff, crc_in;
   byte_type      and_ff, and_in;
   byte_type      or_ff, or_in;
   byte_type      low_ff, low_in;
   byte_type      high_ff, high_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   centi_type  centi_ff, centi_in;

   logic          accept_in;
   logic          go;
   logic          restart;
   logic [CW-1:0] pos;
   logic          is_last;
   byte_type      crc_base, and_new, or_new, crc_next;
   centi_type     centi_conv;

   sspc_crc8 u_crc (
      .crc_cur  (crc_base),
      .data     (in_byte_ff),
      .crc_next (crc_next)
   );

   sspc_convert u_conv (
      .reading_low  (low_ff),
      .reading_high (high_ff),
      .centi        (centi_conv)
   );

   assign restart  = in_start_ff || ({1'b0, count_ff} >= (CW+1)'(FRAME_BYTES));
   assign pos      = restart ? '0 : count_ff;
   assign is_last  = (pos == CW'(FRAME_BYTES - 1));
   assign crc_base = restart ? CRC_INIT : crc_ff;
   assign and_new  = (restart ? AND_INIT : and_ff) & in_byte_ff;
   assign or_new   = (restart ? OR_INIT : or_ff) | in_byte_ff;

   // a byte only waits when it would overwrite a result still held by the sink
   assign go        = in_valid_ff && !(is_last && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !go;
   assign accept_in = req_valid && !req_stall;

   assign in_valid_in  = accept_in || (in_valid_ff && !go);
   assign out_valid_in = (go && is_last) || (out_valid_ff && rsp_stall);

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      and_in    = and_ff;
      or_in     = or_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      status_in = status_ff;
      centi_in  = centi_ff;
      if (go) begin
         if (is_last) begin
            count_in = '0;
            crc_in   = CRC_INIT;
            and_in   = AND_INIT;
            or_in    = OR_INIT;
            low_in   = 8'h00;
            high_in  = 8'h00;
            if (and_new == or_new) begin
               status_in = STATUS_STUCK;
               centi_in  = '0;
            end else if (crc_base != in_byte_ff) begin
               status_in = STATUS_CRC_ERR;
               centi_in  = '0;
            end else begin
               status_in = STATUS_OK;
               centi_in  = centi_conv;
            end
         end else begin
            count_in = pos + CW'(1);
            crc_in   = crc_next;
            and_in   = and_new;
            or_in    = or_new;
            if (pos == '0) begin
               low_in  = in_byte_ff;
               high_in = 8'h00;
            end else if (pos == CW'(1)) begin
               high_in = in_byte_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         and_ff       <= AND_INIT;
         or_ff        <= OR_INIT;
         low_ff       <= 8'h00;
         high_ff      <= 8'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         and_ff       <= and_in;
         or_ff        <= or_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      status_ff <= status_in;
      centi_ff  <= centi_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_centi_deg = centi_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < (CW+1)'(FRAME_BYTES))
      else $error("frame position out of range");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      go && is_last |=> count_ff == '0 && crc_ff == CRC_INIT && and_ff == AND_INIT)
      else $error("frame state not cleared after last byte");

   a_error_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_centi_deg == '0)
      else $error("temperature nonzero on error status");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(status_ff) && $stable(centi_ff))
      else $error("held result overwritten");

endmodule
